/* rtl/sfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types, constants and codes of the serial frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // buffer depths
  localparam int ADDR_DEPTH = 16;
  localparam int MSG_DEPTH  = 16;

  // index and fill widths
  localparam int ADDR_IDX_W = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
  localparam int MSG_IDX_W  = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int ADDR_FILL_W = $clog2(ADDR_DEPTH + 1);
  localparam int MSG_FILL_W  = $clog2(MSG_DEPTH + 1);
  localparam int CNT_W = (ADDR_FILL_W > MSG_FILL_W) ? ADDR_FILL_W : MSG_FILL_W;

  // payload field widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] MSG_LIMIT_RST = 5'd16;

  // framing characters
  localparam logic [BYTE_W-1:0] CH_START = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SEP   = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LZ    = 8'h7A;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO = 2'd0,
    KIND_ADDR = 2'd1,
    KIND_MSG  = 2'd2,
    KIND_END  = 2'd3
  } sfd_kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR_RD,
    ST_ADDR_WR,
    ST_MSG_RD,
    ST_MSG_WR,
    ST_END
  } sfd_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_echo;
    logic load_addr;
    logic load_msg;
    logic load_end;
    logic idx_clr;
    logic idx_inc;
  } sfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic run_mode;
    logic in_frame;
    logic rx_is_cr;
    logic rx_is_alnum;
    logic addr_more;
    logic msg_more;
  } sfd_stat_t;

endpackage

/* rtl/sfd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_rx_if / sfd_res_if
// Valid/ready channels for received bytes and result items.
// ----------------------------------------------------------------------------
interface sfd_rx_if import sfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if import sfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BYTE_W-1:0]  char_value;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] address_count;
  logic [COUNT_W-1:0] message_count;
  logic               last;

  modport source (output valid, output kind, output char_value, output position,
                  output address_count, output message_count, output last,
                  input ready);
  modport sink   (input valid, input kind, input char_value, input position,
                  input address_count, input message_count, input last,
                  output ready);
endinterface

/* rtl/serial_frame_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_top
// Serial byte deframer: alphanumeric echo in setup mode, '+'..'|'..CR frames.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per request; res carries result items
//   (kind, char_value, position, address_count, message_count, last).
//   cfg_we_i / cfg_idx_i / cfg_data_i write run_mode (index 0) and
//   message_limit (index 1); write them only while the block is idle.
// Flow:
//   a byte is taken and its echo item shows on res in the next
//   cycle; bytes stream at one per cycle while res keeps up.
//   A CR that closes a frame starts a drain of the A stored address and M
//   stored message bytes: each stored byte passes a buffer read state and
//   then a result load state, as the buffer read is registered, and a frame
//   end item follows. rx is held off for the whole drain.
// Reset:
//   setup mode, message limit 16, no open frame; buffers are not cleared.
// Stall:
//   while a result waits on res, rx is not ready and the drain pauses.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfd_rx_if.sink                rx,
  sfd_res_if.source             res,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  sfd_cmd_t  cmd;
  sfd_stat_t stat;

  // sequencer
  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx.valid),
    .in_ready_o (rx.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // buffers and result register
  sfd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx.rx_byte),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (res.ready),
    .out_valid_o     (res.valid),
    .kind_o          (res.kind),
    .char_value_o    (res.char_value),
    .position_o      (res.position),
    .address_count_o (res.address_count),
    .message_count_o (res.message_count),
    .last_o          (res.last)
  );

endmodule

/* rtl/sfd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl
// Sequencer: takes bytes, and on frame close drains both buffers in order.
// ----------------------------------------------------------------------------
module sfd_ctrl import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sfd_stat_t stat_i,
  output sfd_cmd_t  cmd_o
);

  sfd_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = stat_i.out_free;
        cmd_o.accept = in_valid_i && stat_i.out_free;
        if (cmd_o.accept) begin
          if (!stat_i.run_mode) begin
            cmd_o.load_echo = stat_i.rx_is_alnum;
          end else if (stat_i.in_frame && stat_i.rx_is_cr) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_ADDR_RD;
          end
        end
      end
      // read cycle: memory output settles for the current index
      ST_ADDR_RD: begin
        if (stat_i.addr_more) begin
          state_d = ST_ADDR_WR;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_MSG_RD;
        end
      end
      ST_ADDR_WR: begin
        if (stat_i.out_free) begin
          cmd_o.load_addr = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = ST_ADDR_RD;
        end
      end
      ST_MSG_RD: begin
        state_d = stat_i.msg_more ? ST_MSG_WR : ST_END;
      end
      ST_MSG_WR: begin
        if (stat_i.out_free) begin
          cmd_o.load_msg = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = ST_MSG_RD;
        end
      end
      ST_END: begin
        if (stat_i.out_free) begin
          cmd_o.load_end = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sfd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_datapath
// Configuration, frame state, address and message buffers, result register.
// ----------------------------------------------------------------------------
module sfd_datapath import sfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [BYTE_W-1:0]     rx_byte_i,
  input  sfd_cmd_t              cmd_i,
  output sfd_stat_t             stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [KIND_W-1:0]     kind_o,
  output logic [BYTE_W-1:0]     char_value_o,
  output logic [POS_W-1:0]      position_o,
  output logic [COUNT_W-1:0]    address_count_o,
  output logic [COUNT_W-1:0]    message_count_o,
  output logic                  last_o
);

  logic                  run_mode_q;
  logic [CFG_DATA_W-1:0] msg_limit_q;
  logic                  in_frame_q, in_message_q;
  logic [ADDR_FILL_W-1:0] addr_fill_q;
  logic [MSG_FILL_W-1:0]  msg_fill_q;
  logic [CNT_W-1:0]      idx_q;

  logic [BYTE_W-1:0] addr_mem [ADDR_DEPTH];
  logic [BYTE_W-1:0] msg_mem  [MSG_DEPTH];
  logic [BYTE_W-1:0] addr_rd_q, msg_rd_q;

  logic        out_valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic [BYTE_W-1:0]  char_q;
  logic [POS_W-1:0]   pos_q;
  logic [COUNT_W-1:0] acnt_q, mcnt_q;
  logic               last_q;

  logic frame_step, is_alnum, addr_we, msg_we, any_load;
  logic [31:0] idx_ext, afill_ext, mfill_ext;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q  <= 1'b0;
      msg_limit_q <= MSG_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RUN_MODE:  run_mode_q  <= cfg_data_i[0];
        CFG_MSG_LIMIT: msg_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte classification
  assign is_alnum = ((rx_byte_i >= CH_0)  && (rx_byte_i <= CH_9))  ||
                    ((rx_byte_i >= CH_UA) && (rx_byte_i <= CH_UZ)) ||
                    ((rx_byte_i >= CH_LA) && (rx_byte_i <= CH_LZ));

  assign frame_step = cmd_i.accept && run_mode_q && in_frame_q &&
                      (rx_byte_i != CH_CR) && (rx_byte_i != CH_SEP);
  assign addr_we = frame_step && !in_message_q &&
                   (32'(addr_fill_q) < 32'(ADDR_DEPTH));
  assign msg_we  = frame_step && in_message_q &&
                   (32'(msg_fill_q) < 32'(msg_limit_q)) &&
                   (32'(msg_fill_q) < 32'(MSG_DEPTH));

  // frame state and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      in_message_q <= 1'b0;
      addr_fill_q  <= '0;
      msg_fill_q   <= '0;
    end else if (cmd_i.accept && run_mode_q) begin
      if (!in_frame_q) begin
        if (rx_byte_i == CH_START) begin
          in_frame_q   <= 1'b1;
          in_message_q <= 1'b0;
          addr_fill_q  <= '0;
          msg_fill_q   <= '0;
        end
      end else if (rx_byte_i == CH_CR) begin
        in_frame_q <= 1'b0;
      end else if (rx_byte_i == CH_SEP) begin
        in_message_q <= 1'b1;
      end else if (addr_we) begin
        addr_fill_q <= addr_fill_q + 1'b1;
      end else if (msg_we) begin
        msg_fill_q <= msg_fill_q + 1'b1;
      end
    end
  end

  // buffers, registered read at the drain index
  always_ff @(posedge clk_i) begin
    if (addr_we) begin
      addr_mem[addr_fill_q[ADDR_IDX_W-1:0]] <= rx_byte_i;
    end
    addr_rd_q <= addr_mem[idx_q[ADDR_IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (msg_we) begin
      msg_mem[msg_fill_q[MSG_IDX_W-1:0]] <= rx_byte_i;
    end
    msg_rd_q <= msg_mem[idx_q[MSG_IDX_W-1:0]];
  end

  // drain index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign idx_ext   = 32'(idx_q);
  assign afill_ext = 32'(addr_fill_q);
  assign mfill_ext = 32'(msg_fill_q);

  // result register
  assign any_load = cmd_i.load_echo || cmd_i.load_addr || cmd_i.load_msg ||
                    cmd_i.load_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (any_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (any_load) begin
      char_q <= '0;
      pos_q  <= '0;
      acnt_q <= '0;
      mcnt_q <= '0;
      last_q <= 1'b0;
      if (cmd_i.load_echo) begin
        kind_q <= KIND_ECHO;
        char_q <= rx_byte_i;
        last_q <= 1'b1;
      end else if (cmd_i.load_addr) begin
        kind_q <= KIND_ADDR;
        char_q <= addr_rd_q;
        pos_q  <= idx_ext[POS_W-1:0];
      end else if (cmd_i.load_msg) begin
        kind_q <= KIND_MSG;
        char_q <= msg_rd_q;
        pos_q  <= idx_ext[POS_W-1:0];
      end else begin
        kind_q <= KIND_END;
        acnt_q <= afill_ext[COUNT_W-1:0];
        mcnt_q <= mfill_ext[COUNT_W-1:0];
        last_q <= 1'b1;
      end
    end
  end

  // status to the controller
  always_comb begin
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.run_mode    = run_mode_q;
    stat_o.in_frame    = in_frame_q;
    stat_o.rx_is_cr    = (rx_byte_i == CH_CR);
    stat_o.rx_is_alnum = is_alnum;
    stat_o.addr_more   = (idx_ext < afill_ext);
    stat_o.msg_more    = (idx_ext < mfill_ext);
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign char_value_o    = char_q;
  assign position_o      = pos_q;
  assign address_count_o = acnt_q;
  assign message_count_o = mcnt_q;
  assign last_o          = last_q;

endmodule

/* rtl/sfd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rx_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic [KIND_W-1:0]  kind_i,
  input logic [BYTE_W-1:0]  char_value_i,
  input logic [POS_W-1:0]   position_i,
  input logic [COUNT_W-1:0] address_count_i,
  input logic [COUNT_W-1:0] message_count_i,
  input logic               last_i
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(kind_i) &&
    $stable(char_value_i) && $stable(position_i) && $stable(last_i))
    else $error("stalled result changed");

  // no byte is taken while a result is stuck
  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |-> !rx_ready_i)
    else $error("byte taken while result stalled");

  // echo items are single-item runs with no position or counts
  a_echo_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == KIND_ECHO |-> last_i && position_i == '0 &&
    address_count_i == '0 && message_count_i == '0)
    else $error("malformed echo item");

  // stored characters never close a run
  a_char_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (kind_i == KIND_ADDR || kind_i == KIND_MSG) |-> !last_i &&
    address_count_i == '0 && message_count_i == '0)
    else $error("stored character marked last");

  // frame end closes the run and carries no character
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && kind_i == KIND_END |-> last_i && char_value_i == '0 &&
    position_i == '0)
    else $error("malformed frame end");

endmodule

bind serial_frame_deframer_top sfd_checker u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_ready_i      (rx.ready),
  .res_valid_i     (res.valid),
  .res_ready_i     (res.ready),
  .kind_i          (res.kind),
  .char_value_i    (res.char_value),
  .position_i      (res.position),
  .address_count_i (res.address_count),
  .message_count_i (res.message_count),
  .last_i          (res.last)
);
